// File: rtl/integer_matrix_multiply_top_assert.svh
// Assertion macros used by the checker file of the matrix multiply block.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IMM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/imm_pkg.sv
// Package with the types, constants and helpers of the matrix multiply block.
package imm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 4;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  k;
    logic [IDX_W-1:0]  row;
    logic [DATA_W-1:0] a;
  } tok_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  row;
    logic [DATA_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  k;
    logic [DATA_W-1:0] data;
  } bwr_t;

  typedef struct packed {
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] kd;
    logic [DIM_W-1:0] cb;
  } dims_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiply block: controller, cell chain and result register.
//
//   Channel   Handshake                  Payload
//   config    cfg_we_i                   cfg_idx_i, cfg_wdata_i
//   input     in_valid_i / in_ready_o    element_i
//   output    out_valid_o / out_ready_i  product_o, out_row_o, out_col_o, last_of_run_o
//
// Loading accepts one element per cycle, A and then B, written into the A store and the cells.
// After the last element the sequencer steps through rows_a * max(inner_dim, cols_b) slots,
// with tokens in the first inner_dim slots of each row. The last result passes the sequencer's
// token register, the cell registers up to column cols_b - 1 and the output register. Input is
// held off from the last element until the last result has been transferred. A stalled output
// freezes the whole chain. Reset clears control state only; stores are undefined until loaded.
module integer_matrix_multiply_top import imm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DIM_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] element_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] product_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic                     last_of_run_o
);

  tok_t              tok_in [MAX_DIM];
  tok_t              tok_nx [MAX_DIM-1];
  res_t              res    [MAX_DIM];
  bwr_t              bwr;
  dims_t             dims;
  logic              adv, done;
  logic              hit;
  logic [DATA_W-1:0] sel_val;
  logic [IDX_W-1:0]  sel_row, sel_col;
  logic              out_vld_q;
  logic [DATA_W-1:0] product_q;
  logic [IDX_W-1:0]  row_q, col_q;
  logic              last_q;

  assign adv  = !out_vld_q || out_ready_i;
  assign done = out_vld_q && out_ready_i && last_q;

  imm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .element_i   (element_i),
    .adv_i       (adv),
    .done_i      (done),
    .tok_o       (tok_in[0]),
    .bwr_o       (bwr),
    .dims_o      (dims)
  );

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    if (c < MAX_DIM - 1) begin : g_mid
      imm_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .wr_en_i   (bwr.en && (bwr.col == IDX_W'(c))),
        .wr_k_i    (bwr.k),
        .wr_data_i (bwr.data),
        .tok_i     (tok_in[c]),
        .tok_o     (tok_nx[c]),
        .res_o     (res[c])
      );
      assign tok_in[c+1] = tok_nx[c];
    end else begin : g_end
      imm_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .adv_i     (adv),
        .wr_en_i   (bwr.en && (bwr.col == IDX_W'(c))),
        .wr_k_i    (bwr.k),
        .wr_data_i (bwr.data),
        .tok_i     (tok_in[c]),
        .tok_o     (),
        .res_o     (res[c])
      );
    end
  end

  always_comb begin
    hit     = 1'b0;
    sel_val = '0;
    sel_row = '0;
    sel_col = '0;
    for (int c = 0; c < MAX_DIM; c++) begin
      if (res[c].valid && (DIM_W'(c) < dims.cb)) begin
        hit     = 1'b1;
        sel_val = sel_val | res[c].value;
        sel_row = sel_row | res[c].row;
        sel_col = sel_col | IDX_W'(c);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      product_q <= sel_val;
      row_q     <= sel_row;
      col_q     <= sel_col;
      last_q    <= ({1'b0, sel_row} == dims.ra - DIM_W'(1)) &&
                   ({1'b0, sel_col} == dims.cb - DIM_W'(1));
    end
  end

  assign out_valid_o   = out_vld_q;
  assign product_o     = product_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/imm_cell.sv
// One multiply-accumulate cell of the chain, holding one column of matrix B.
module imm_cell import imm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_k_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  tok_t              tok_i,
  output tok_t              tok_o,
  output res_t              res_o
);

  logic [DATA_W-1:0] bcol_q [MAX_DIM];
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] sum;
  tok_t              tok_q;
  res_t              res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      bcol_q[wr_k_i] <= wr_data_i;
    end
  end

  always_comb begin
    sum = (tok_q.first ? '0 : acc_q) + prod_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      res_q <= '0;
    end else if (adv_i) begin
      tok_q       <= tok_i;
      res_q.valid <= tok_q.valid && tok_q.last;
      res_q.row   <= tok_q.row;
      res_q.value <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= tok_i.a * bcol_q[tok_i.k];
      if (tok_q.valid) begin
        acc_q <= sum;
      end
    end
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

endmodule

// File: rtl/imm_ctrl.sv
// Load counters, storage of matrix A and the sequencer that feeds the cell chain.
module imm_ctrl import imm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DATA_W-1:0]    element_i,
  input  logic                 adv_i,
  input  logic                 done_i,
  output tok_t                 tok_o,
  output bwr_t                 bwr_o,
  output dims_t                dims_o
);

  typedef enum logic [1:0] {ST_LOAD, ST_RUN, ST_DRAIN} state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  ra_q, kd_q, cb_q;
  logic [CNT_W-1:0]  lc_q;
  logic [IDX_W-1:0]  bk_q, bc_q;
  logic [IDX_W-1:0]  row_q, slot_q;
  logic [ADDR_W-1:0] abase_q;
  logic              tok_vld_q;
  logic              tok_first_q, tok_last_q;
  logic [IDX_W-1:0]  tok_k_q, tok_row_q;
  logic [DATA_W-1:0] tok_a_q;
  logic [DATA_W-1:0] store_a [STORE_DEPTH];

  logic [CNT_W-1:0]  size_a, total;
  logic              in_xfer, in_a, last_in, cfg_hit, inject, slot_end;
  logic [DIM_W-1:0]  pmax;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    size_a   = CNT_W'(ra_q) * CNT_W'(kd_q);
    total    = size_a + CNT_W'(kd_q) * CNT_W'(cb_q);
    in_xfer  = in_valid_i && in_ready_o;
    in_a     = lc_q < size_a;
    last_in  = lc_q == total - CNT_W'(1);
    cfg_hit  = cfg_we_i && (cfg_idx_i == REG_ROWS_A || cfg_idx_i == REG_INNER_DIM ||
                            cfg_idx_i == REG_COLS_B);
    pmax     = ((kd_q > cb_q) ? kd_q : cb_q) - DIM_W'(1);
    inject   = {1'b0, slot_q} < kd_q;
    slot_end = {1'b0, slot_q} == pmax;
    rd_addr  = abase_q + ADDR_W'(slot_q);
  end

  assign in_ready_o = state_q == ST_LOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      ra_q      <= DIM_W'(1);
      kd_q      <= DIM_W'(1);
      cb_q      <= DIM_W'(1);
      lc_q      <= '0;
      bk_q      <= '0;
      bc_q      <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      abase_q   <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      if (adv_i) begin
        tok_vld_q <= (state_q == ST_RUN) && inject;
      end
      if (cfg_hit) begin
        case (cfg_idx_i)
          REG_ROWS_A:    ra_q <= eff_dim(cfg_wdata_i);
          REG_INNER_DIM: kd_q <= eff_dim(cfg_wdata_i);
          REG_COLS_B:    cb_q <= eff_dim(cfg_wdata_i);
          default:       ;
        endcase
        lc_q <= '0;
        bk_q <= '0;
        bc_q <= '0;
      end else begin
        case (state_q)
          ST_LOAD: begin
            if (in_xfer) begin
              if (last_in) begin
                lc_q    <= '0;
                bk_q    <= '0;
                bc_q    <= '0;
                row_q   <= '0;
                slot_q  <= '0;
                abase_q <= '0;
                state_q <= ST_RUN;
              end else begin
                lc_q <= lc_q + CNT_W'(1);
                if (!in_a) begin
                  if ({1'b0, bc_q} == cb_q - DIM_W'(1)) begin
                    bc_q <= '0;
                    bk_q <= bk_q + IDX_W'(1);
                  end else begin
                    bc_q <= bc_q + IDX_W'(1);
                  end
                end
              end
            end
          end
          ST_RUN: begin
            if (adv_i) begin
              if (slot_end) begin
                slot_q  <= '0;
                row_q   <= row_q + IDX_W'(1);
                abase_q <= abase_q + ADDR_W'(kd_q);
                if ({1'b0, row_q} == ra_q - DIM_W'(1)) begin
                  state_q <= ST_DRAIN;
                end
              end else begin
                slot_q <= slot_q + IDX_W'(1);
              end
            end
          end
          ST_DRAIN: begin
            if (done_i) begin
              state_q <= ST_LOAD;
            end
          end
          default: state_q <= ST_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_a) begin
      store_a[lc_q[ADDR_W-1:0]] <= element_i;
    end
    if (adv_i) begin
      tok_a_q     <= store_a[rd_addr];
      tok_k_q     <= slot_q;
      tok_row_q   <= row_q;
      tok_first_q <= slot_q == '0;
      tok_last_q  <= {1'b0, slot_q} == kd_q - DIM_W'(1);
    end
  end

  always_comb begin
    tok_o.valid = tok_vld_q;
    tok_o.first = tok_first_q;
    tok_o.last  = tok_last_q;
    tok_o.k     = tok_k_q;
    tok_o.row   = tok_row_q;
    tok_o.a     = tok_a_q;
    bwr_o.en    = in_xfer && !in_a;
    bwr_o.col   = bc_q;
    bwr_o.k     = bk_q;
    bwr_o.data  = element_i;
    dims_o.ra   = ra_q;
    dims_o.kd   = kd_q;
    dims_o.cb   = cb_q;
  end

endmodule

// File: rtl/imm_checker.sv
// Port-level assertion checker of the matrix multiply block and its bind statement.
`include "integer_matrix_multiply_top_assert.svh"

module imm_checker import imm_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] product_o,
  input logic [IDX_W-1:0]         out_col_o,
  input logic                     last_of_run_o
);

  `IMM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(product_o) && $stable(out_col_o), "stalled result changed")
  `IMM_ASSERT_NOW(a_no_load_in_burst, out_valid_o, !in_ready_o,
    "input accepted while results are pending")
  `IMM_ASSERT_NXT(a_last_ends_burst, out_valid_o && out_ready_i && last_of_run_o,
    !out_valid_o, "result shown after the final element")
  `IMM_ASSERT_NXT(a_busy_until_last, out_valid_o && out_ready_i && !last_of_run_o,
    !in_ready_o, "input reopened before the final element")

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (.*);
